// ===== hdl/scn_pkg.sv =====
// ============================================================================
// scn_pkg
// Shared types, codes and constants of the scanset token scanner.
// ============================================================================
package scn_pkg;

    localparam int LENGTH_BITS    = 10;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOI  = 2'd2;

    localparam logic [1:0] CLASS_NONSPACE = 2'd0;
    localparam logic [1:0] CLASS_IN_MAP   = 2'd1;
    localparam logic [1:0] CLASS_OUT_MAP  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SKIP_LEADING_SPACE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOKEN_CLASS        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LENGTH         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DROP_TERMINATOR    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_MAP_W0       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_MAP_W1       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_MAP_W2       = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_MAP_W3       = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             token_byte;
        logic [LENGTH_BITS-1:0] token_length;
        logic [7:0]             terminator_byte;
        logic                   has_terminator;
        logic                   last;
    } out_item_t;

    typedef struct packed {
        logic                   skip_leading_space;
        logic [1:0]             token_class;
        logic [LENGTH_BITS-1:0] max_length;
        logic                   drop_terminator;
        logic [255:0]           class_map;
    } cfg_t;

    typedef struct packed {
        out_item_t first;
        out_item_t second;
        logic      two;
    } entry_t;

endpackage

// ===== hdl/scanset_token_scanner.sv =====
// ============================================================================
// scanset_token_scanner
// Cuts a byte stream into scanf-style tokens: token bytes, then end records.
// ============================================================================
// A result passes through a queue entry and then the output register.
// Throughput: one input beat per cycle unless the queue is full; a beat with
// two results yields two output beats, which the four-entry queue absorbs.
// Reset: registers take their defaults, no token pending, queue empty.
module scanset_token_scanner (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [scn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [scn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  scn_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output scn_pkg::out_item_t                  out_data
);

    scn_pkg::cfg_t   cfg_reg;
    scn_pkg::entry_t push_entry;
    scn_pkg::entry_t head;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_leading_space <= 1'b1;
            cfg_reg.token_class        <= scn_pkg::CLASS_NONSPACE;
            cfg_reg.max_length         <= '1;
            cfg_reg.drop_terminator    <= 1'b0;
            cfg_reg.class_map          <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                scn_pkg::REG_SKIP_LEADING_SPACE: cfg_reg.skip_leading_space <= cfg_data[0];
                scn_pkg::REG_TOKEN_CLASS:        cfg_reg.token_class <= cfg_data[1:0];
                scn_pkg::REG_MAX_LENGTH:
                    cfg_reg.max_length <= cfg_data[scn_pkg::LENGTH_BITS-1:0];
                scn_pkg::REG_DROP_TERMINATOR:    cfg_reg.drop_terminator <= cfg_data[0];
                scn_pkg::REG_CLASS_MAP_W0:       cfg_reg.class_map[63:0]    <= cfg_data;
                scn_pkg::REG_CLASS_MAP_W1:       cfg_reg.class_map[127:64]  <= cfg_data;
                scn_pkg::REG_CLASS_MAP_W2:       cfg_reg.class_map[191:128] <= cfg_data;
                scn_pkg::REG_CLASS_MAP_W3:       cfg_reg.class_map[255:192] <= cfg_data;
                default:                         cfg_reg.drop_terminator <= cfg_reg.drop_terminator;
            endcase
        end
    end

    scn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_stall   (in_stall),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    scn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    scn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_empty))
        else $error("pop from empty queue");

    a_length_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind != scn_pkg::KIND_END) |-> (out_data.token_length == '0))
        else $error("token length on a non-end beat");
`endif

endmodule

// ===== hdl/scn_front.sv =====
// ============================================================================
// scn_front
// Accepts input beats, classifies each byte and tracks the token in progress;
// pushes the one or two result records of a beat, if any, into the queue.
// ============================================================================
module scn_front (
    input  logic               clk,
    input  logic               rst_n,
    input  scn_pkg::cfg_t      cfg,
    input  logic               in_valid,
    input  scn_pkg::in_item_t  in_data,
    output logic               in_stall,
    input  logic               q_full,
    output logic               push,
    output scn_pkg::entry_t    push_entry
);

    logic                            collecting_reg;
    logic                            collecting_next;
    logic [scn_pkg::LENGTH_BITS-1:0] count_reg;
    logic [scn_pkg::LENGTH_BITS-1:0] count_next;
    logic [scn_pkg::LENGTH_BITS-1:0] limit;
    logic [scn_pkg::LENGTH_BITS-1:0] count_inc;
    logic [7:0]                      b;
    logic                            accept;
    logic                            is_space;
    logic                            in_map;
    logic                            member;
    logic                            skip;
    logic [1:0]                      n;
    scn_pkg::out_item_t              r0;
    scn_pkg::out_item_t              r1;

    function automatic scn_pkg::out_item_t make_result(
        input logic [1:0]                      kind,
        input logic [7:0]                      tb,
        input logic [scn_pkg::LENGTH_BITS-1:0] len,
        input logic [7:0]                      term,
        input logic                            has
    );
        scn_pkg::out_item_t r;
        r.kind            = kind;
        r.token_byte      = tb;
        r.token_length    = len;
        r.terminator_byte = term;
        r.has_terminator  = has;
        r.last            = 1'b0;
        return r;
    endfunction

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign b         = in_data.data_byte;
    assign limit     = (cfg.max_length == '0) ? scn_pkg::LENGTH_BITS'(1) : cfg.max_length;
    assign count_inc = count_reg + scn_pkg::LENGTH_BITS'(1);
    assign is_space  = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    assign in_map    = cfg.class_map[b];
    assign skip      = cfg.skip_leading_space && is_space;

    always_comb
    begin
        unique case (cfg.token_class)
            scn_pkg::CLASS_IN_MAP:  member = in_map;
            scn_pkg::CLASS_OUT_MAP: member = !in_map;
            default:
                member = !(b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A);
        endcase
    end

    always_comb
    begin
        n               = 2'd0;
        r0              = make_result(scn_pkg::KIND_EOI, 8'd0, '0, 8'd0, 1'b0);
        r1              = r0;
        collecting_next = collecting_reg;
        count_next      = count_reg;
        if (in_data.end_of_input)
        begin
            n = 2'd1;
            if (collecting_reg)
                r0 = make_result(scn_pkg::KIND_END, 8'd0, count_reg, 8'd0, 1'b0);
            collecting_next = 1'b0;
            count_next      = '0;
        end
        else if (collecting_reg)
        begin
            if (member)
            begin
                n  = 2'd1;
                r0 = make_result(scn_pkg::KIND_BYTE, b, '0, 8'd0, 1'b0);
                count_next = count_inc;
                if (count_inc >= limit)
                begin
                    n  = 2'd2;
                    r1 = make_result(scn_pkg::KIND_END, 8'd0, count_inc, 8'd0, 1'b0);
                    collecting_next = 1'b0;
                    count_next      = '0;
                end
            end
            else
            begin
                n  = 2'd1;
                r0 = make_result(scn_pkg::KIND_END, 8'd0, count_reg, b, 1'b1);
                collecting_next = 1'b0;
                count_next      = '0;
                if (!cfg.drop_terminator && !skip)
                begin
                    n  = 2'd2;
                    r1 = make_result(scn_pkg::KIND_END, 8'd0, '0, b, 1'b1);
                end
            end
        end
        else if (!skip)
        begin
            n = 2'd1;
            if (member)
            begin
                r0 = make_result(scn_pkg::KIND_BYTE, b, '0, 8'd0, 1'b0);
                if (limit == scn_pkg::LENGTH_BITS'(1))
                begin
                    n  = 2'd2;
                    r1 = make_result(scn_pkg::KIND_END, 8'd0, scn_pkg::LENGTH_BITS'(1),
                                     8'd0, 1'b0);
                end
                else
                begin
                    collecting_next = 1'b1;
                    count_next      = scn_pkg::LENGTH_BITS'(1);
                end
            end
            else
            begin
                r0 = make_result(scn_pkg::KIND_END, 8'd0, '0, b, 1'b1);
            end
        end
        r0.last = (n == 2'd1);
        r1.last = 1'b1;
    end

    assign push              = accept && (n != 2'd0);
    assign push_entry.first  = r0;
    assign push_entry.second = r1;
    assign push_entry.two    = (n == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== hdl/scn_queue.sv =====
// ============================================================================
// scn_queue
// Short FIFO of result entries between the front and the back.
// ============================================================================
module scn_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scn_pkg::entry_t push_entry,
    input  logic            pop,
    output scn_pkg::entry_t head,
    output logic            full,
    output logic            empty
);

    scn_pkg::entry_t                    mem [scn_pkg::QUEUE_DEPTH];
    logic [scn_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [scn_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [scn_pkg::QUEUE_PTR_BITS:0]   count_reg;
    logic [scn_pkg::QUEUE_PTR_BITS:0]   count_next;

    assign full  = (count_reg == (scn_pkg::QUEUE_PTR_BITS+1)'(scn_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (scn_pkg::QUEUE_PTR_BITS+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (scn_pkg::QUEUE_PTR_BITS+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + scn_pkg::QUEUE_PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + scn_pkg::QUEUE_PTR_BITS'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/scn_back.sv =====
// ============================================================================
// scn_back
// Drains queue entries one result beat at a time into the output register.
// ============================================================================
module scn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  scn_pkg::entry_t    head,
    input  logic               q_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output scn_pkg::out_item_t out_data
);

    logic               out_valid_reg;
    logic               out_valid_next;
    scn_pkg::out_item_t out_data_reg;
    logic               sel_reg;
    logic               sel_next;
    logic               load;

    assign load           = !q_empty && (!out_valid_reg || !out_stall);
    assign pop            = load && (sel_reg || !head.two);
    assign sel_next       = load ? !pop : sel_reg;
    assign out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= sel_reg ? head.second : head.first;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

endmodule

// ===== tb/scanset_token_scanner_tb.sv =====
// ============================================================================
// scanset_token_scanner_tb
// Checks the token scanner against a cycle-free model of its token rules.
// A directed table walks reset values, field extremes and the corner cases:
// skipped whitespace, empty tokens, rescanned and dropped terminators, the
// length limit and end of input. Random phases follow, each under its own
// register settings and idling mode, one of them with a long output hold-off.
// Every accepted result beat is compared field by field, in order.
// ============================================================================
module scanset_token_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scn_pkg::*;

    localparam logic [1:0]  CLASS_UNUSED = 2'd3;
    localparam int          PHASE_BEATS  = 62;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          TIMEOUT_NS   = 2_000_000;
    localparam logic [47:0] WHITE_BYTES  = 48'h20090A0B0C0D;

    typedef struct packed {
        logic                      is_cfg;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  val;
        in_item_t                  item;
        logic                      typed;
        logic [1:0]                n_typed;
        out_item_t                 e0;
        out_item_t                 e1;
    } row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    in_item_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_item_t                 out_data;

    // scanner state and register copies
    logic                   mdl_skip  = 1'b1;
    logic [1:0]             mdl_class = CLASS_NONSPACE;
    logic [LENGTH_BITS-1:0] mdl_max   = 10'd1023;
    logic                   mdl_drop  = 1'b0;
    logic [255:0]           mdl_map   = '0;
    logic                   tok_open  = 1'b0;
    logic [LENGTH_BITS-1:0] tok_len   = '0;

    out_item_t beat_results[$];
    out_item_t pending_results[$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_off  = 0;

    int fail_count  = 0;
    int beats_sent  = 0;
    int beats_back  = 0;
    int reg_writes  = 0;
    int tokens_done = 0;
    int empty_done  = 0;
    int cut_done    = 0;
    int eoi_seen    = 0;

    scanset_token_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic out_item_t mk(logic [1:0] kind, logic [7:0] tb,
                                     logic [LENGTH_BITS-1:0] len, logic [7:0] term,
                                     logic has, logic last);
        out_item_t r;
        r.kind            = kind;
        r.token_byte      = tb;
        r.token_length    = len;
        r.terminator_byte = term;
        r.has_terminator  = has;
        r.last            = last;
        return r;
    endfunction

    function automatic bit is_white(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit in_class(logic [7:0] b);
        case (mdl_class)
            CLASS_IN_MAP:  return mdl_map[b];
            CLASS_OUT_MAP: return !mdl_map[b];
            default:       return !(b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A);
        endcase
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_cap();
        return (mdl_max == '0) ? LENGTH_BITS'(1) : mdl_max;
    endfunction

    function automatic void open_token(logic [7:0] b);
        if (mdl_skip && is_white(b))
            return;
        if (in_class(b))
        begin
            beat_results.push_back(mk(KIND_BYTE, b, '0, '0, 1'b0, 1'b0));
            tok_open = 1'b1;
            tok_len  = LENGTH_BITS'(1);
            if (tok_len >= len_cap())
            begin
                beat_results.push_back(mk(KIND_END, '0, tok_len, '0, 1'b0, 1'b0));
                tok_open = 1'b0;
                tok_len  = '0;
            end
        end
        else
            beat_results.push_back(mk(KIND_END, '0, '0, b, 1'b1, 1'b0));
    endfunction

    function automatic void scan_byte(in_item_t it);
        logic [7:0] b;
        b = it.data_byte;
        beat_results.delete();
        if (it.end_of_input)
        begin
            if (tok_open)
                beat_results.push_back(mk(KIND_END, '0, tok_len, '0, 1'b0, 1'b0));
            else
                beat_results.push_back(mk(KIND_EOI, '0, '0, '0, 1'b0, 1'b0));
            tok_open = 1'b0;
            tok_len  = '0;
        end
        else if (tok_open)
        begin
            if (in_class(b))
            begin
                beat_results.push_back(mk(KIND_BYTE, b, '0, '0, 1'b0, 1'b0));
                tok_len = tok_len + 1'b1;
                if (tok_len >= len_cap())
                begin
                    beat_results.push_back(mk(KIND_END, '0, tok_len, '0, 1'b0, 1'b0));
                    tok_open = 1'b0;
                    tok_len  = '0;
                end
            end
            else
            begin
                beat_results.push_back(mk(KIND_END, '0, tok_len, b, 1'b1, 1'b0));
                tok_open = 1'b0;
                tok_len  = '0;
                if (!mdl_drop)
                    open_token(b);
            end
        end
        else
            open_token(b);
        if (beat_results.size() > 0)
            beat_results[beat_results.size()-1].last = 1'b1;
    endfunction

    function automatic in_item_t rand_beat();
        in_item_t it;
        int       r;
        r = $urandom_range(0, 99);
        it.end_of_input = ($urandom_range(0, 99) < 4);
        if (r < 20)
            it.data_byte = WHITE_BYTES[8*$urandom_range(0, 5) +: 8];
        else if (r < 65)
            it.data_byte = 8'($urandom_range(33, 126));
        else
            it.data_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic row_t cfg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] val);
        row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic row_t typed_row(logic [7:0] b, logic eoi, logic [1:0] n,
                                       out_item_t e0, out_item_t e1);
        row_t r;
        r                   = '0;
        r.item.data_byte    = b;
        r.item.end_of_input = eoi;
        r.typed             = 1'b1;
        r.n_typed           = n;
        r.e0                = e0;
        r.e1                = e1;
        return r;
    endfunction

    function automatic row_t beat_row(logic [7:0] b, logic eoi);
        row_t r;
        r       = typed_row(b, eoi, 2'd0, '0, '0);
        r.typed = 1'b0;
        return r;
    endfunction

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        reg_writes++;
        case (idx)
            REG_SKIP_LEADING_SPACE: mdl_skip  = val[0];
            REG_TOKEN_CLASS:        mdl_class = val[1:0];
            REG_MAX_LENGTH:         mdl_max   = val[LENGTH_BITS-1:0];
            REG_DROP_TERMINATOR:    mdl_drop  = val[0];
            REG_CLASS_MAP_W0:       mdl_map[63:0]    = val;
            REG_CLASS_MAP_W1:       mdl_map[127:64]  = val;
            REG_CLASS_MAP_W2:       mdl_map[191:128] = val;
            REG_CLASS_MAP_W3:       mdl_map[255:192] = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic skip, logic [1:0] cls, logic [LENGTH_BITS-1:0] maxl,
                                  logic drop, logic [255:0] map);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        write_reg(REG_SKIP_LEADING_SPACE, {noise[63:1], skip});
        write_reg(REG_TOKEN_CLASS, {noise[63:2], cls});
        write_reg(REG_MAX_LENGTH, {noise[63:LENGTH_BITS], maxl});
        write_reg(REG_DROP_TERMINATOR, {noise[63:1], drop});
        write_reg(REG_CLASS_MAP_W0, map[63:0]);
        write_reg(REG_CLASS_MAP_W1, map[127:64]);
        write_reg(REG_CLASS_MAP_W2, map[191:128]);
        write_reg(REG_CLASS_MAP_W3, map[255:192]);
    endtask

    task automatic drive_item(in_item_t it, logic typed, logic [1:0] n_typed,
                              out_item_t e0, out_item_t e1);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        scan_byte(it);
        foreach (beat_results[i])
        begin
            if (beat_results[i].kind == KIND_END)
            begin
                tokens_done++;
                if (beat_results[i].token_length == '0)
                    empty_done++;
                else if (!beat_results[i].has_terminator && !it.end_of_input)
                    cut_done++;
            end
        end
        if (it.end_of_input)
            eoi_seen++;
        if (typed)
        begin
            if (n_typed >= 2'd1)
                pending_results.push_back(e0);
            if (n_typed >= 2'd2)
                pending_results.push_back(e1);
        end
        else
            foreach (beat_results[i])
                pending_results.push_back(beat_results[i]);
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            $error("result beat with nothing expected: kind %0d", got.kind);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        beats_back++;
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count++;
        end
        if (got.token_byte !== want.token_byte)
        begin
            $error("token_byte: expected %02h, got %02h", want.token_byte, got.token_byte);
            fail_count++;
        end
        if (got.token_length !== want.token_length)
        begin
            $error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
            fail_count++;
        end
        if (got.terminator_byte !== want.terminator_byte)
        begin
            $error("terminator_byte: expected %02h, got %02h",
                   want.terminator_byte, got.terminator_byte);
            fail_count++;
        end
        if (got.has_terminator !== want.has_terminator)
        begin
            $error("has_terminator: expected %0d, got %0d",
                   want.has_terminator, got.has_terminator);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
                check_result(out_data);
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
                hold_off--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        row_t                   plan[$];
        logic                   skip;
        logic [1:0]             cls;
        logic [LENGTH_BITS-1:0] maxl;
        logic                   drop;
        logic [255:0]           map;

        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back(typed_row(8'h00, 1'b1, 2'd1, mk(KIND_EOI, '0, '0, '0, 1'b0, 1'b1), '0));
        plan.push_back(typed_row(8'h20, 1'b0, 2'd0, '0, '0));
        plan.push_back(typed_row(8'h0C, 1'b0, 2'd0, '0, '0));
        plan.push_back(typed_row(8'h61, 1'b0, 2'd1,
                                 mk(KIND_BYTE, 8'h61, '0, '0, 1'b0, 1'b1), '0));
        plan.push_back(beat_row(8'h00, 1'b0));
        plan.push_back(beat_row(8'hFF, 1'b0));
        plan.push_back(beat_row(8'h0B, 1'b0));
        plan.push_back(beat_row(8'h20, 1'b0));
        plan.push_back(beat_row(8'h41, 1'b0));
        plan.push_back(typed_row(8'h5A, 1'b1, 2'd1,
                                 mk(KIND_END, '0, LENGTH_BITS'(1), '0, 1'b0, 1'b1), '0));
        plan.push_back(cfg_row(REG_SKIP_LEADING_SPACE, 64'd0));
        plan.push_back(typed_row(8'h20, 1'b0, 2'd1,
                                 mk(KIND_END, '0, '0, 8'h20, 1'b1, 1'b1), '0));
        plan.push_back(beat_row(8'h7A, 1'b0));
        plan.push_back(beat_row(8'h0A, 1'b0));
        plan.push_back(cfg_row(REG_MAX_LENGTH, 64'd0));
        plan.push_back(typed_row(8'h42, 1'b0, 2'd2,
                                 mk(KIND_BYTE, 8'h42, '0, '0, 1'b0, 1'b0),
                                 mk(KIND_END, '0, LENGTH_BITS'(1), '0, 1'b0, 1'b1)));
        plan.push_back(cfg_row(REG_MAX_LENGTH, 64'd2));
        plan.push_back(cfg_row(REG_DROP_TERMINATOR, 64'd1));
        plan.push_back(beat_row(8'h43, 1'b0));
        plan.push_back(beat_row(8'h44, 1'b0));
        plan.push_back(beat_row(8'h45, 1'b0));
        plan.push_back(beat_row(8'h09, 1'b0));
        plan.push_back(cfg_row(REG_TOKEN_CLASS, 64'(CLASS_UNUSED)));
        plan.push_back(beat_row(8'h0D, 1'b0));
        plan.push_back(cfg_row(REG_CLASS_MAP_W1, 64'h0000_0000_0000_0002));
        plan.push_back(cfg_row(REG_CLASS_MAP_W3, 64'h8000_0000_0000_0000));
        plan.push_back(cfg_row(REG_TOKEN_CLASS, 64'(CLASS_IN_MAP)));
        plan.push_back(beat_row(8'h41, 1'b0));
        plan.push_back(beat_row(8'hFF, 1'b0));
        plan.push_back(beat_row(8'h41, 1'b0));
        plan.push_back(beat_row(8'h42, 1'b0));
        plan.push_back(cfg_row(REG_CLASS_MAP_W0, '1));
        plan.push_back(cfg_row(REG_CLASS_MAP_W2, '1));
        plan.push_back(cfg_row(REG_TOKEN_CLASS, 64'(CLASS_OUT_MAP)));
        plan.push_back(beat_row(8'h80, 1'b0));
        plan.push_back(beat_row(8'h7E, 1'b0));
        plan.push_back(beat_row(8'h00, 1'b1));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].val);
            else
                drive_item(plan[i].item, plan[i].typed, plan[i].n_typed,
                           plan[i].e0, plan[i].e1);
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            for (int w = 0; w < 8; w++)
                map[32*w +: 32] = $urandom;
            skip = 1'($urandom_range(0, 1));
            drop = 1'($urandom_range(0, 1));
            cls  = 2'($urandom_range(0, 3));
            maxl = ($urandom_range(0, 9) < 8) ? LENGTH_BITS'($urandom_range(1, 8))
                                              : LENGTH_BITS'($urandom_range(0, 1023));
            case (phase)
                0: apply_settings(1'b1, CLASS_NONSPACE, 10'd1023, 1'b0, map);
                1: apply_settings(1'b0, CLASS_NONSPACE, maxl, 1'b0, map);
                2: apply_settings(1'b1, CLASS_IN_MAP, 10'd1023, 1'b1, map);
                3: apply_settings(1'b0, CLASS_OUT_MAP, 10'd1, 1'b0, map);
                4: apply_settings(skip, CLASS_UNUSED, 10'd0, drop, map);
                5: apply_settings(1'b1, CLASS_IN_MAP, 10'd3, 1'b0, '1);
                6: apply_settings(1'b0, CLASS_OUT_MAP, 10'd1023, 1'b0, '1);
                7: apply_settings(skip, CLASS_IN_MAP, maxl, drop, '0);
                default: apply_settings(skip, cls, maxl, drop, map);
            endcase
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 72; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            // hold the output long enough to back the block up into its input
            if (phase == 4)
                hold_off = HOLD_CYCLES;
            for (int k = 0; k < PHASE_BEATS; k++)
                drive_item(rand_beat(), 1'b0, 2'd0, '0, '0);
        end

        settle();
        repeat (10) @(posedge clk);

        $display("Sent %0d input beats under %0d register writes; checked %0d result beats.",
                 beats_sent, reg_writes, beats_back);
        $display("Tokens ended %0d (empty %0d, cut at length limit %0d); end of input %0d.",
                 tokens_done, empty_done, cut_done, eoi_seen);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== scanset_token_scanner.f =====
hdl/scn_pkg.sv
hdl/scn_front.sv
hdl/scn_queue.sv
hdl/scn_back.sv
hdl/scanset_token_scanner.sv
tb/scanset_token_scanner_tb.sv
